>>> src/mexp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the modular exponentiation unit.
package mexp_pkg;

	localparam int FIELD_W = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_RED,
		ST_BIT,
		ST_MACC,
		ST_SQR,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MSEL_REDUCE,
		MSEL_ACC,
		MSEL_SQR
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_sel_t sel;
		logic     mul_step;
		logic     acc_write;
		logic     pw_write;
		logic     exp_shift;
		logic     out_write;
	} dp_cmd_t;

	typedef struct packed {
		logic mod_zero;
		logic exp_lsb;
		logic exp_zero;
		logic mul_last;
		logic out_free;
	} dp_sts_t;

endpackage

>>> src/mexp_if.sv
`timescale 1ns / 1ps
// Request channels: operand input and result output.
interface mexp_in_if;
	logic                         valid;
	logic                         ready;
	logic [mexp_pkg::FIELD_W-1:0] base;
	logic [mexp_pkg::FIELD_W-1:0] exponent;
	logic [mexp_pkg::FIELD_W-1:0] modulus;

	modport source (output valid, output base, output exponent, output modulus, input ready);
	modport sink (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mexp_out_if;
	logic                         valid;
	logic                         ready;
	logic [mexp_pkg::FIELD_W-1:0] power_result;
	logic                         zero_modulus_error;

	modport source (output valid, output power_result, output zero_modulus_error, input ready);
	modport sink (input valid, input power_result, input zero_modulus_error, output ready);
endinterface

>>> src/mexp_dp.sv
`timescale 1ns / 1ps
// Datapath: operand registers, bit-serial modular multiplier, result register.
module mexp_dp #(
	parameter int W = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mexp_pkg::dp_cmd_t            cmd,
	output mexp_pkg::dp_sts_t            sts,
	input  logic [mexp_pkg::FIELD_W-1:0] base,
	input  logic [mexp_pkg::FIELD_W-1:0] exponent,
	input  logic [mexp_pkg::FIELD_W-1:0] modulus,
	output logic [mexp_pkg::FIELD_W-1:0] power_result,
	output logic                         zero_modulus_error,
	output logic                         res_valid,
	input  logic                         res_ready
);
	import mexp_pkg::*;

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  acc_q, pw_q, exp_q, mod_q;
	logic [W-1:0]  ma_q, mb_q, r_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  res_power_q;
	logic          res_err_q;
	logic          res_valid_q;

	logic [W+1:0]  t, t_m1, t_m2, m_x, m2_x;
	logic [W-1:0]  r_next;

	// One multiplier step: r = (2r + b_msb*a) mod m, with t < 3m
	always_comb begin
		m_x  = {2'b00, mod_q};
		m2_x = {1'b0, mod_q, 1'b0};
		t    = {1'b0, r_q, 1'b0} + (mb_q[W-1] ? {2'b00, ma_q} : '0);
		t_m1 = t - m_x;
		t_m2 = t - m2_x;
		if (t >= m2_x) begin
			r_next = t_m2[W-1:0];
		end else if (t >= m_x) begin
			r_next = t_m1[W-1:0];
		end else begin
			r_next = t[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= (modulus[W-1:0] == W'(1)) ? '0 : W'(1);
			pw_q  <= base[W-1:0];
			exp_q <= exponent[W-1:0];
			mod_q <= modulus[W-1:0];
		end
		if (cmd.acc_write) begin
			acc_q <= r_next;
		end
		if (cmd.pw_write) begin
			pw_q <= r_next;
		end
		if (cmd.exp_shift) begin
			exp_q <= exp_q >> 1;
		end
		if (cmd.mul_start) begin
			r_q   <= '0;
			cnt_q <= '0;
			case (cmd.sel)
				MSEL_REDUCE: begin
					ma_q <= W'(1);
					mb_q <= pw_q;
				end
				MSEL_ACC: begin
					ma_q <= acc_q;
					mb_q <= pw_q;
				end
				default: begin
					ma_q <= pw_q;
					mb_q <= pw_q;
				end
			endcase
		end else if (cmd.mul_step) begin
			r_q   <= r_next;
			mb_q  <= mb_q << 1;
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.out_write) begin
			res_power_q <= (mod_q == '0) ? '0 : acc_q;
			res_err_q   <= (mod_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_write) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign sts.mod_zero = (mod_q == '0);
	assign sts.exp_lsb  = exp_q[0];
	assign sts.exp_zero = (exp_q == '0);
	assign sts.mul_last = (cnt_q == CW'(W - 1));
	assign sts.out_free = !res_valid_q || res_ready;

	assign power_result       = FIELD_W'(res_power_q);
	assign zero_modulus_error = res_err_q;
	assign res_valid          = res_valid_q;

endmodule

>>> src/mexp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing the square-and-multiply steps.
module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mexp_pkg::dp_sts_t sts,
	output mexp_pkg::dp_cmd_t cmd
);
	import mexp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				state_d = sts.mod_zero ? ST_FINISH : ST_RED;
			end
			ST_RED: begin
				if (sts.mul_last) state_d = ST_BIT;
			end
			ST_BIT: begin
				if (sts.exp_zero) begin
					state_d = ST_FINISH;
				end else begin
					state_d = sts.exp_lsb ? ST_MACC : ST_SQR;
				end
			end
			ST_MACC: begin
				if (sts.mul_last) state_d = ST_SQR;
			end
			ST_SQR: begin
				if (sts.mul_last) state_d = ST_BIT;
			end
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_START: begin
				cmd.mul_start = !sts.mod_zero;
				cmd.sel       = MSEL_REDUCE;
			end
			ST_RED: begin
				cmd.mul_step = 1'b1;
				cmd.pw_write = sts.mul_last;
			end
			ST_BIT: begin
				cmd.mul_start = !sts.exp_zero;
				cmd.sel       = sts.exp_lsb ? MSEL_ACC : MSEL_SQR;
			end
			ST_MACC: begin
				// square starts right as the multiply finishes
				cmd.mul_step  = 1'b1;
				cmd.acc_write = sts.mul_last;
				cmd.mul_start = sts.mul_last;
				cmd.sel       = MSEL_SQR;
			end
			ST_SQR: begin
				cmd.mul_step  = 1'b1;
				cmd.pw_write  = sts.mul_last;
				cmd.exp_shift = sts.mul_last;
			end
			ST_FINISH: begin
				cmd.out_write = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> src/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// Sequence: a start state, a base reduction, then per exponent bit up to its top set bit a bit
// state, an optional multiply and a squaring, then a finish state; a zero modulus skips to finish.
// Throughput: one request at a time; the next is taken in the cycle after the result is written.
// A finished result sits in an output register, so the next request is taken meanwhile.
// Reset (arst_n, async, active low) clears the state machine and the result valid flag.
module modular_exponentiation_unit #(
	parameter int OPERAND_WIDTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	mexp_in_if.sink    operands,
	mexp_out_if.source result
);
	import mexp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_ready;
	logic    res_valid;

	// Sequencer: reduce base, then per exponent bit an optional multiply
	// into the accumulator followed by a squaring of the power.
	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operands.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Operand registers, shift-add modular multiplier and output register.
	// Input bits above OPERAND_WIDTH are dropped at load.
	mexp_dp #(
		.W (OPERAND_WIDTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.base               (operands.base),
		.exponent           (operands.exponent),
		.modulus            (operands.modulus),
		.power_result       (result.power_result),
		.zero_modulus_error (result.zero_modulus_error),
		.res_valid          (res_valid),
		.res_ready          (result.ready)
	);

	assign operands.ready = in_ready;
	assign result.valid   = res_valid;

	// Once a request is taken the unit is not ready in the cycle after.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.ready |=> !operands.ready)
		else $error("input still ready right after accept");

	// Writing the output register always presents a result.
	a_write_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_write |=> result.valid)
		else $error("result not valid after output write");

	// A result only appears because the controller wrote one.
	a_result_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.out_write))
		else $error("result valid without output write");

endmodule

>>> test/modular_exponentiation_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the modular exponentiation unit.
module modular_exponentiation_unit_tb;
	import mexp_pkg::*;

	typedef logic [FIELD_W-1:0] word_t;

	localparam word_t WORD_MAX = {FIELD_W{1'b1}};
	localparam word_t WORD_TOP = word_t'(1) << (FIELD_W - 1);
	// The stall limit covers the worst single request plus the sink hold-off.
	localparam int HOLD_CYCLES = 20000;
	localparam int STALL_LIMIT = 120000;
	localparam int TAIL_CYCLES = 50;
	localparam int RANDOM_REQUESTS = 82;

	// One expected result plus the operands that produced it, kept for reporting.
	typedef struct {
		word_t base;
		word_t exponent;
		word_t modulus;
		word_t power;
		logic  mod_zero;
	} power_exp_t;

	logic clk;
	logic arst_n;
	logic steady;      // no random gaps on either side while set
	int   stall_cycles;

	mexp_in_if  operands_ch ();
	mexp_out_if result_ch ();

	modular_exponentiation_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.operands(operands_ch),
		.result  (result_ch)
	);

	// Exact (a * b) mod m through a double-width product.
	function automatic word_t mul_mod(word_t a, word_t b, word_t m);
		logic [2*FIELD_W-1:0] prod;
		prod = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b};
		return word_t'(prod % {{FIELD_W{1'b0}}, m});
	endfunction

	// Right-to-left square-and-multiply over all exponent bits.
	function automatic power_exp_t predict_power(word_t b, word_t e, word_t m);
		power_exp_t x;
		word_t      acc;
		word_t      sq;
		x.base     = b;
		x.exponent = e;
		x.modulus  = m;
		x.power    = '0;
		x.mod_zero = 1'b1;
		if (m == '0) begin
			return x;
		end
		acc = word_t'(1) % m;
		sq  = b % m;
		for (int i = 0; i < FIELD_W; i++) begin
			if (e[i]) begin
				acc = mul_mod(acc, sq, m);
			end
			sq = mul_mod(sq, sq, m);
		end
		x.power    = acc;
		x.mod_zero = 1'b0;
		return x;
	endfunction

	class modexp_scoreboard;
		power_exp_t owed[$];
		int         errors;
		int         checked;

		function new();
			errors  = 0;
			checked = 0;
		endfunction

		function void note_request(word_t b, word_t e, word_t m);
			owed.push_back(predict_power(b, e, m));
		endfunction

		function void check_result(word_t p, logic z);
			power_exp_t x;
			checked++;
			if (owed.size() == 0) begin
				$display("%0t: result with no request pending: power_result=%h err=%b",
					$time, p, z);
				errors++;
				return;
			end
			x = owed.pop_front();
			if (p !== x.power) begin
				$display("%0t: power_result for %h^%h mod %h: expected %h, actual %h",
					$time, x.base, x.exponent, x.modulus, x.power, p);
				errors++;
			end
			if (z !== x.mod_zero) begin
				$display("%0t: zero_modulus_error for %h^%h mod %h: expected %b, actual %b",
					$time, x.base, x.exponent, x.modulus, x.mod_zero, z);
				errors++;
			end
		endfunction
	endclass

	modexp_scoreboard sb = new();

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic word_t rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Offer one request from the falling edge, hold it until the unit takes it.
	task automatic send_request(word_t b, word_t e, word_t m);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 8) begin
			operands_ch.valid = 1'b0;
			@(negedge clk);
		end
		operands_ch.valid    = 1'b1;
		operands_ch.base     = b;
		operands_ch.exponent = e;
		operands_ch.modulus  = m;
		@(posedge clk);
		while (!operands_ch.ready) begin
			@(posedge clk);
		end
		sb.note_request(b, e, m);
	endtask

	// Mostly short exponents keep the run short; some full-width ones hit every bit.
	task automatic send_random_request();
		word_t b;
		word_t e;
		word_t m;
		int    r;
		int    len;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			m = '0;
		end else if (r < 20) begin
			m = word_t'($urandom_range(1, 16));
		end else begin
			m = rand_word();
		end
		b = ($urandom_range(0, 9) == 0) ? word_t'($urandom_range(0, 40)) : rand_word();
		if ($urandom_range(0, 99) < 30) begin
			e = rand_word();
		end else begin
			len = $urandom_range(0, 16);
			e   = (len == 0) ? '0 : (rand_word() >> (FIELD_W - len));
		end
		send_request(b, e, m);
	endtask

	// Result sink: random back-pressure, plus one long hold-off that fills the unit.
	initial begin : result_sink
		bit held;
		held = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sb.checked >= 50) begin
				held = 1'b1;
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_ch.ready = arst_n && (steady || $urandom_range(0, 99) >= 8);
			end
		end
	end

	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			sb.check_result(result_ch.power_result, result_ch.zero_modulus_error);
		end
	end

	// Watchdog: any handshake on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (operands_ch.valid && operands_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n               = 1'b0;
		steady               = 1'b0;
		operands_ch.valid    = 1'b0;
		operands_ch.base     = '0;
		operands_ch.exponent = '0;
		operands_ch.modulus  = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// zero modulus, with and without other operands set
		send_request('0, '0, '0);
		send_request(WORD_MAX, WORD_MAX, '0);
		// zero exponent: 1, or 0 for modulus one; 0^0 counts as 1; then small exponents
		send_request(word_t'(5), '0, word_t'(7));
		send_request(word_t'(5), '0, word_t'(1));
		send_request('0, '0, word_t'(13));
		send_request(WORD_MAX, WORD_MAX, word_t'(1));
		send_request('0, word_t'(5), word_t'(13));
		send_request(word_t'(3), word_t'(1), word_t'(7));
		// base at or above the modulus gets reduced first
		send_request(word_t'(20), word_t'(3), word_t'(7));
		send_request(word_t'(7), word_t'(9), word_t'(7));
		send_request(word_t'(1), WORD_MAX, word_t'(2));
		send_request(word_t'(123456789), word_t'(65537), word_t'(2));
		// full-width operands, modulus top bit set so the sum runs past the operand width
		send_request(WORD_MAX, word_t'(2), WORD_MAX);
		send_request(word_t'(2), word_t'(64), WORD_MAX);
		send_request(WORD_MAX - 1, WORD_MAX, WORD_MAX);
		send_request(WORD_TOP + 5, WORD_MAX, WORD_TOP);
		send_request(WORD_MAX, WORD_MAX, WORD_MAX - 58);
		send_request(rand_word(), WORD_TOP, rand_word() | 1);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			steady = (n >= 40 && n < 70);
			send_random_request();
		end
		steady = 1'b0;
		@(negedge clk);
		operands_ch.valid = 1'b0;

		while (sb.owed.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> modular_exponentiation_unit.f
src/mexp_pkg.sv
src/mexp_if.sv
src/mexp_dp.sv
src/mexp_ctrl.sv
src/modular_exponentiation_unit.sv
test/modular_exponentiation_unit_tb.sv
